[rtl/core/request_response_route_table_defines.svh]
// Assertion macros for the request/response route table.
`ifndef REQUEST_RESPONSE_ROUTE_TABLE_DEFINES_SVH
`define REQUEST_RESPONSE_ROUTE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define RRRT_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error(msg);
// Condition must never be true outside reset.
`define RRRT_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error(msg);
`else
`define RRRT_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define RRRT_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif
`endif

[rtl/core/rrrt_pkg.sv]
// Shared constants and types of the request/response route table.
package rrrt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Added on a wrapped stamp distance (gives the table's one-short wrap age)
  localparam logic [31:0] AGE_WRAP = 32'hFFFF_FFFF;

  typedef logic [IDX_W-1:0] idx_t;

  // One table entry as held in the entry RAM
  typedef struct packed {
    logic [31:0] uid;
    logic [7:0]  func;
    logic [3:0]  seq;
    logic [3:0]  conn;
    logic [31:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Entry slot whose RAM data is on the read port this cycle
  typedef struct packed {
    logic v;
    idx_t idx;
  } age_req_t;

  // Registered result of the age/match unit
  typedef struct packed {
    logic        v;
    idx_t        idx;
    logic [31:0] age;
    logic        match;
    logic [3:0]  conn;
  } age_rsp_t;

endpackage

[rtl/core/rrrt_ram.sv]
// Generic single-port-write, registered-read RAM.
module rrrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/rrrt_age_unit.sv]
// Shared age and key-match unit, one entry per cycle, registered output.
module rrrt_age_unit import rrrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  age_req_t    req,
  input  entry_t      ent,
  input  logic [31:0] now,
  input  logic [31:0] key_uid,
  input  logic [7:0]  key_func,
  input  logic [3:0]  key_seq,
  output age_rsp_t    rsp
);

  logic [32:0] diff;
  logic [31:0] age;
  logic        match;

  logic        v_q;
  idx_t        idx_q;
  logic [31:0] age_q;
  logic        match_q;
  logic [3:0]  conn_q;

  // Wrapped distance: now + (WRAP - then) == (now - then) + WRAP mod 2^32
  assign diff  = {1'b0, now} - {1'b0, ent.stamp};
  assign age   = diff[32] ? (diff[31:0] + AGE_WRAP) : diff[31:0];
  assign match = (ent.uid == key_uid) && (ent.func == key_func) && (ent.seq == key_seq);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else begin
      v_q <= req.v;
    end
  end

  always_ff @(posedge clk) begin
    idx_q   <= req.idx;
    age_q   <= age;
    match_q <= match;
    conn_q  <= ent.conn;
  end

  assign rsp = '{v: v_q, idx: idx_q, age: age_q, match: match_q, conn: conn_q};

endmodule

[rtl/core/request_response_route_table.sv]
// Top level of the request/response route table: sequencer, valid bits and result register.
`include "request_response_route_table_defines.svh"

// Remembers which connection issued each request so its response can be routed back.
// One word is taken at a time; req_stall is high while a word is in work. Record, lookup
// and disconnect words walk all TABLE_ENTRIES entries of the entry RAM, one entry per
// cycle through a single age/match unit and one age comparator. Broadcast records and
// broadcast lookups skip the walk. A finished result sits in the output register while
// the next word is accepted. Entry valid bits are flip-flops cleared by reset; entry data
// needs no clearing.
module request_response_route_table import rrrt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  op,
  input  logic [31:0] uid,
  input  logic [7:0]  func_id,
  input  logic [3:0]  seq_num,
  input  logic        reply_wanted,
  input  logic [3:0]  conn_id,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        found,
  output logic [3:0]  route_conn
);

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_PEEK   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_DROP   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t             state;
  op_t                op_q;
  logic [31:0]        key_uid;
  logic [7:0]         key_func;
  logic [3:0]         key_seq;
  logic [3:0]         key_conn;
  logic [31:0]        stamp;
  logic [TABLE_ENTRIES-1:0] valid_bits;
  logic [CNT_W-1:0]   rd_cnt;
  logic               s1_v;
  idx_t               s1_idx;
  logic [31:0]        best;
  idx_t               victim;
  logic               placed;
  logic               hit;
  logic [3:0]         hit_conn;
  logic               res_found;
  logic [3:0]         res_conn;

  logic               req_fire;
  logic               bcast;
  logic               scan_end;
  logic               ent_v;
  logic               older;
  logic               ram_we;
  entry_t             wr_ent;
  logic [ENTRY_W-1:0] ram_rdata;
  age_req_t           age_req;
  age_rsp_t           s2;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;

  // Broadcast words change nothing and answer "not found"
  assign bcast = (op != OP_DROP) &&
                 ((seq_num == 4'd0) || (uid == 32'd0) ||
                  ((op == OP_RECORD) && !reply_wanted));

  // Walk finished once every read is issued and the pipe has drained
  assign scan_end = (rd_cnt == CNT_W'(TABLE_ENTRIES)) && !s1_v && !s2.v;

  // Compare stage: valid bit of the entry in hand, and the shared age comparator
  assign ent_v = valid_bits[s2.idx];
  assign older = s2.age > best;

  // Entry RAM write, only on commit of a record
  assign ram_we = (state == S_COMMIT) && (op_q == OP_RECORD);
  assign wr_ent = '{uid: key_uid, func: key_func, seq: key_seq, conn: key_conn, stamp: stamp};

  rrrt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (victim),
    .wdata (wr_ent),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign age_req = '{v: s1_v, idx: s1_idx};

  rrrt_age_unit u_age (
    .clk      (clk),
    .rst      (rst),
    .req      (age_req),
    .ent      (entry_t'(ram_rdata)),
    .now      (stamp),
    .key_uid  (key_uid),
    .key_func (key_func),
    .key_seq  (key_seq),
    .rsp      (s2)
  );

  // Sequencer, table state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      stamp      <= 32'd0;
      valid_bits <= '0;
      s1_v       <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      s1_v <= 1'b0;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            op_q     <= op_t'(op);
            key_uid  <= uid;
            key_func <= func_id;
            key_seq  <= seq_num;
            key_conn <= conn_id;
            rd_cnt   <= '0;
            placed   <= 1'b0;
            hit      <= 1'b0;
            victim   <= '0;
            if (bcast) begin
              res_found <= 1'b0;
              res_conn  <= 4'd0;
              state     <= S_RESULT;
            end else begin
              if (op == OP_RECORD) begin
                stamp <= stamp + 32'd1;
              end
              state <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          // Issue one RAM read a cycle
          if (rd_cnt != CNT_W'(TABLE_ENTRIES)) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
            s1_v   <= 1'b1;
            s1_idx <= rd_cnt[IDX_W-1:0];
          end

          // One entry a cycle through the comparator
          if (s2.v) begin
            case (op_q) inside
              OP_RECORD: begin
                if (!placed) begin
                  if (!ent_v) begin
                    placed <= 1'b1;
                    victim <= s2.idx;
                  end else if (s2.idx == '0) begin
                    best   <= s2.age;
                    victim <= '0;
                  end else if (older) begin
                    best   <= s2.age;
                    victim <= s2.idx;
                  end
                end
              end
              OP_PEEK, OP_REMOVE: begin
                if (ent_v && s2.match && (!hit || older)) begin
                  hit      <= 1'b1;
                  best     <= s2.age;
                  victim   <= s2.idx;
                  hit_conn <= s2.conn;
                end
              end
              default: begin
                if (ent_v && (s2.conn == key_conn)) begin
                  valid_bits[s2.idx] <= 1'b0;
                end
              end
            endcase
          end

          if (scan_end) begin
            state <= S_COMMIT;
          end
        end

        S_COMMIT: begin
          res_found <= 1'b0;
          res_conn  <= 4'd0;
          case (op_q) inside
            OP_RECORD: begin
              valid_bits[victim] <= 1'b1;
            end
            OP_PEEK, OP_REMOVE: begin
              res_found <= hit;
              res_conn  <= hit ? hit_conn : 4'd0;
              if ((op_q == OP_REMOVE) && hit) begin
                valid_bits[victim] <= 1'b0;
              end
            end
            default: begin
            end
          endcase
          state <= S_RESULT;
        end

        S_RESULT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid  <= 1'b1;
            found      <= res_found;
            route_conn <= res_conn;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `RRRT_ASSERT(a_stamp_on_record, clk, rst, ($past(!rst) && !$stable(stamp)) |-> $past(req_valid && !req_stall && (op == OP_RECORD)), "stamp moved without a record word")
  `RRRT_ASSERT(a_drained_at_commit, clk, rst, (state == S_COMMIT) |-> (!s1_v && !s2.v), "entry walk still in flight at commit")
  `RRRT_ASSERT_NEVER(a_miss_routes_zero, clk, rst, rsp_valid && !found && (route_conn != 4'd0), "route given without a match")

endmodule
